@@ hw/rtl/m3i_pkg.sv @@
// Shared types, widths and cofactor index tables for the 3x3 matrix inverse.
package m3i_pkg;

    // Element format and the widths that follow from it.
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int N_ELEM    = 9;
    localparam int PROD_W    = 2 * WORD_BITS;
    localparam int ADJ_W     = PROD_W + 1;
    localparam int LO_W      = WORD_BITS;
    localparam int HI_W      = ADJ_W - LO_W;
    localparam int PART_W    = WORD_BITS + LO_W + 1;
    localparam int DET_W     = WORD_BITS + ADJ_W + 2;
    localparam int MAG_W     = DET_W;
    localparam int QB        = WORD_BITS + 2;
    localparam int SHIFT     = 2 * FRAC_BITS + 1;
    localparam int NUM_W     = ADJ_W + SHIFT;
    localparam int LIMIT_W   = 63;
    localparam int PIPE_LAT  = QB + 7;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [ADJ_W-1:0]     t_adj;
    typedef logic signed [PART_W-1:0]    t_part;
    typedef logic signed [DET_W-1:0]     t_det;
    typedef logic [MAG_W-1:0]            t_mag;
    typedef logic [QB-1:0]               t_quo;
    typedef logic [LIMIT_W-1:0]          t_limit;

    // One input item: the matrix in row-major order.
    typedef struct packed {
        t_word in_r0c0;
        t_word in_r0c1;
        t_word in_r0c2;
        t_word in_r1c0;
        t_word in_r1c1;
        t_word in_r1c2;
        t_word in_r2c0;
        t_word in_r2c1;
        t_word in_r2c2;
    } t_in_item;

    // One result item: the inverse and its status flags.
    typedef struct packed {
        t_word out_r0c0;
        t_word out_r0c1;
        t_word out_r0c2;
        t_word out_r1c0;
        t_word out_r1c1;
        t_word out_r1c2;
        t_word out_r2c0;
        t_word out_r2c1;
        t_word out_r2c2;
        logic  is_singular;
        logic  saturated;
    } t_out_item;

    // Control that travels with each item through the divider.
    typedef struct packed {
        logic              valid;
        logic              singular;
        logic [N_ELEM-1:0] neg;
        logic [N_ELEM-1:0] ovf;
    } t_div_ctl;

    // Cofactor k is m[A]*m[B] - m[C]*m[D].
    localparam logic [3:0] CROSS_A [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] CROSS_B [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] CROSS_C [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] CROSS_D [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

endpackage

@@ hw/rtl/m3i_cofactor.sv @@
// Two pipeline stages that form the nine adjugate entries exactly.
module m3i_cofactor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  m3i_pkg::t_in_item i_item,
    output logic              o_valid,
    output m3i_pkg::t_adj     o_adj  [m3i_pkg::N_ELEM],
    output m3i_pkg::t_word    o_row0 [3]
);

    m3i_pkg::t_word m [m3i_pkg::N_ELEM];
    m3i_pkg::t_prod r_pa [m3i_pkg::N_ELEM];
    m3i_pkg::t_prod r_pb [m3i_pkg::N_ELEM];
    m3i_pkg::t_word r_row1 [3];
    m3i_pkg::t_adj  r_adj [m3i_pkg::N_ELEM];
    m3i_pkg::t_word r_row2 [3];
    logic           r_valid1;
    logic           r_valid2;

    // Unpack the item into an indexable matrix.
    assign m[0] = i_item.in_r0c0;
    assign m[1] = i_item.in_r0c1;
    assign m[2] = i_item.in_r0c2;
    assign m[3] = i_item.in_r1c0;
    assign m[4] = i_item.in_r1c1;
    assign m[5] = i_item.in_r1c2;
    assign m[6] = i_item.in_r2c0;
    assign m[7] = i_item.in_r2c1;
    assign m[8] = i_item.in_r2c2;

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    // Stage one: the eighteen element products.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
            r_pa[k] <= m3i_pkg::t_prod'(m[m3i_pkg::CROSS_A[k]])
                     * m3i_pkg::t_prod'(m[m3i_pkg::CROSS_B[k]]);
            r_pb[k] <= m3i_pkg::t_prod'(m[m3i_pkg::CROSS_C[k]])
                     * m3i_pkg::t_prod'(m[m3i_pkg::CROSS_D[k]]);
        end
        for (int j = 0; j < 3; j++) begin
            r_row1[j] <= m[j];
        end
    end

    // Stage two: the cross differences.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
            r_adj[k] <= m3i_pkg::t_adj'(r_pa[k]) - m3i_pkg::t_adj'(r_pb[k]);
        end
        r_row2 <= r_row1;
    end

    assign o_valid = r_valid2;
    assign o_adj   = r_adj;
    assign o_row0  = r_row2;

endmodule

@@ hw/rtl/m3i_det.sv @@
// Four pipeline stages: determinant, magnitudes, singular test and divider setup.
module m3i_det (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  m3i_pkg::t_adj     i_adj  [m3i_pkg::N_ELEM],
    input  m3i_pkg::t_word    i_row0 [3],
    input  m3i_pkg::t_limit   i_limit,
    output m3i_pkg::t_div_ctl o_ctl,
    output m3i_pkg::t_mag     o_rem  [m3i_pkg::N_ELEM],
    output m3i_pkg::t_quo     o_nlow [m3i_pkg::N_ELEM],
    output m3i_pkg::t_mag     o_div
);

    logic [2:0]                      r_valid;
    m3i_pkg::t_part                  r_pl [3];
    m3i_pkg::t_part                  r_ph [3];
    m3i_pkg::t_adj                   r_adj3 [m3i_pkg::N_ELEM];
    m3i_pkg::t_det                   r_det;
    m3i_pkg::t_adj                   r_adj4 [m3i_pkg::N_ELEM];
    m3i_pkg::t_mag                   r_mag;
    logic                            r_dneg;
    logic [m3i_pkg::ADJ_W-1:0]       r_amag [m3i_pkg::N_ELEM];
    logic [m3i_pkg::N_ELEM-1:0]      r_aneg;
    m3i_pkg::t_div_ctl               r_ctl;
    m3i_pkg::t_mag                   r_rem [m3i_pkg::N_ELEM];
    m3i_pkg::t_quo                   r_nlow [m3i_pkg::N_ELEM];
    m3i_pkg::t_mag                   r_div;
    m3i_pkg::t_det                   n_det;

    // Valid bits of stages three to five; stage six keeps its own in the control word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // Stage three: first-row elements times cofactor halves.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_pl[j] <= m3i_pkg::t_part'(i_row0[j])
                     * m3i_pkg::t_part'($signed({1'b0, i_adj[3*j][m3i_pkg::LO_W-1:0]}));
            r_ph[j] <= m3i_pkg::t_part'(i_row0[j])
                     * m3i_pkg::t_part'($signed(i_adj[3*j][m3i_pkg::ADJ_W-1:m3i_pkg::LO_W]));
        end
        r_adj3 <= i_adj;
    end

    // Stage four: sum of the partial products gives the exact determinant.
    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + (m3i_pkg::t_det'(r_ph[j]) <<< m3i_pkg::LO_W)
                          + m3i_pkg::t_det'(r_pl[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_det  <= n_det;
        r_adj4 <= r_adj3;
    end

    // Stage five: magnitudes and signs.
    always_ff @(posedge i_clk) begin
        r_dneg <= r_det[m3i_pkg::DET_W-1];
        r_mag  <= r_det[m3i_pkg::DET_W-1] ? m3i_pkg::t_mag'(-r_det) : m3i_pkg::t_mag'(r_det);
        for (int l = 0; l < m3i_pkg::N_ELEM; l++) begin
            r_aneg[l] <= r_adj4[l][m3i_pkg::ADJ_W-1];
            r_amag[l] <= r_adj4[l][m3i_pkg::ADJ_W-1] ? m3i_pkg::ADJ_W'(-r_adj4[l])
                                                      : m3i_pkg::ADJ_W'(r_adj4[l]);
        end
    end

    // Stage six: singular test, overflow test and the divider's first remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= r_valid[2];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [m3i_pkg::NUM_W-1:0] num;
        logic [m3i_pkg::MAG_W-1:0] head;
        r_ctl.singular <= (r_mag == '0) || (r_mag < m3i_pkg::t_mag'(i_limit));
        for (int l = 0; l < m3i_pkg::N_ELEM; l++) begin
            num              = {r_amag[l], {m3i_pkg::SHIFT{1'b0}}};
            head             = m3i_pkg::t_mag'(num >> m3i_pkg::QB);
            r_rem[l]        <= head;
            r_nlow[l]       <= num[m3i_pkg::QB-1:0];
            r_ctl.ovf[l]    <= head >= r_mag;
            r_ctl.neg[l]    <= r_aneg[l] ^ r_dneg;
        end
        r_div <= r_mag;
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_nlow = r_nlow;
    assign o_div  = r_div;

endmodule

@@ hw/rtl/m3i_divider.sv @@
// Restoring divider pipeline: one quotient bit per stage for all nine lanes.
module m3i_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  m3i_pkg::t_div_ctl i_ctl,
    input  m3i_pkg::t_mag     i_rem  [m3i_pkg::N_ELEM],
    input  m3i_pkg::t_quo     i_nlow [m3i_pkg::N_ELEM],
    input  m3i_pkg::t_mag     i_div,
    output m3i_pkg::t_div_ctl o_ctl,
    output m3i_pkg::t_quo     o_q    [m3i_pkg::N_ELEM]
);

    m3i_pkg::t_mag     r_rem  [m3i_pkg::QB][m3i_pkg::N_ELEM];
    m3i_pkg::t_quo     r_q    [m3i_pkg::QB][m3i_pkg::N_ELEM];
    m3i_pkg::t_quo     r_nlow [m3i_pkg::QB][m3i_pkg::N_ELEM];
    m3i_pkg::t_mag     r_div  [m3i_pkg::QB];
    m3i_pkg::t_div_ctl r_ctl  [m3i_pkg::QB];

    for (genvar s = 0; s < m3i_pkg::QB; s++) begin : g_step
        m3i_pkg::t_mag     rem_in  [m3i_pkg::N_ELEM];
        m3i_pkg::t_quo     q_in    [m3i_pkg::N_ELEM];
        m3i_pkg::t_quo     nlow_in [m3i_pkg::N_ELEM];
        m3i_pkg::t_mag     div_in;
        m3i_pkg::t_div_ctl ctl_in;
        m3i_pkg::t_mag     n_rem   [m3i_pkg::N_ELEM];
        m3i_pkg::t_quo     n_q     [m3i_pkg::N_ELEM];

        // The first stage takes the setup values, later ones the previous stage.
        if (s == 0) begin : g_first
            assign rem_in  = i_rem;
            assign nlow_in = i_nlow;
            assign div_in  = i_div;
            assign ctl_in  = i_ctl;
            for (genvar l = 0; l < m3i_pkg::N_ELEM; l++) begin : g_lane
                assign q_in[l] = '0;
            end
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign q_in    = r_q[s-1];
            assign nlow_in = r_nlow[s-1];
            assign div_in  = r_div[s-1];
            assign ctl_in  = r_ctl[s-1];
        end

        // Shift in the next numerator bit and subtract the divisor if it fits.
        always_comb begin
            logic [m3i_pkg::MAG_W:0] shifted;
            logic [m3i_pkg::MAG_W:0] diff;
            logic                    ge;
            for (int l = 0; l < m3i_pkg::N_ELEM; l++) begin
                shifted = {rem_in[l], nlow_in[l][m3i_pkg::QB-1-s]};
                diff    = shifted - {1'b0, div_in};
                ge      = shifted >= {1'b0, div_in};
                n_rem[l] = ge ? diff[m3i_pkg::MAG_W-1:0] : shifted[m3i_pkg::MAG_W-1:0];
                n_q[l]   = q_in[l];
                n_q[l][m3i_pkg::QB-1-s] = ge;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s] <= '0;
            end else begin
                r_ctl[s] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_q[s]    <= n_q;
            r_nlow[s] <= nlow_in;
            r_div[s]  <= div_in;
        end
    end

    assign o_ctl = r_ctl[m3i_pkg::QB-1];
    assign o_q   = r_q[m3i_pkg::QB-1];

endmodule

@@ hw/rtl/m3i_round.sv @@
// Output stage: rounding, sign, saturation and the singular override.
module m3i_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  m3i_pkg::t_div_ctl  i_ctl,
    input  m3i_pkg::t_quo      i_q [m3i_pkg::N_ELEM],
    output logic               o_strobe,
    output m3i_pkg::t_out_item o_item
);

    localparam logic [m3i_pkg::QB:0] POS_LIM = (m3i_pkg::QB+1)'((64'd1 << (m3i_pkg::WORD_BITS-1)) - 64'd1);
    localparam logic [m3i_pkg::QB:0] NEG_LIM = (m3i_pkg::QB+1)'(64'd1 << (m3i_pkg::WORD_BITS-1));
    localparam m3i_pkg::t_word       W_MAX   = {1'b0, {(m3i_pkg::WORD_BITS-1){1'b1}}};
    localparam m3i_pkg::t_word       W_MIN   = {1'b1, {(m3i_pkg::WORD_BITS-1){1'b0}}};

    m3i_pkg::t_word     n_val [m3i_pkg::N_ELEM];
    logic               n_sat;
    m3i_pkg::t_out_item r_item;
    logic               r_strobe;

    // Round half away from zero, then clip to the word range in the direction of the sign.
    always_comb begin
        logic [m3i_pkg::QB:0] qr;
        logic                 clip;
        n_sat = 1'b0;
        for (int l = 0; l < m3i_pkg::N_ELEM; l++) begin
            qr   = ({1'b0, i_q[l]} + (m3i_pkg::QB+1)'(1)) >> 1;
            clip = i_ctl.ovf[l] || (i_ctl.neg[l] ? (qr > NEG_LIM) : (qr > POS_LIM));
            if (i_ctl.singular) begin
                n_val[l] = '0;
            end else if (clip) begin
                n_val[l] = i_ctl.neg[l] ? W_MIN : W_MAX;
                n_sat    = 1'b1;
            end else if (i_ctl.neg[l]) begin
                n_val[l] = m3i_pkg::t_word'(-qr);
            end else begin
                n_val[l] = m3i_pkg::t_word'(qr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item.out_r0c0    <= n_val[0];
        r_item.out_r0c1    <= n_val[1];
        r_item.out_r0c2    <= n_val[2];
        r_item.out_r1c0    <= n_val[3];
        r_item.out_r1c1    <= n_val[4];
        r_item.out_r1c2    <= n_val[5];
        r_item.out_r2c0    <= n_val[6];
        r_item.out_r2c1    <= n_val[7];
        r_item.out_r2c2    <= n_val[8];
        r_item.is_singular <= i_ctl.singular;
        r_item.saturated   <= n_sat;
    end

    assign o_strobe = r_strobe;
    assign o_item   = r_item;

endmodule

@@ hw/rtl/matrix3x3_inverse_core.sv @@
// 3x3 signed Q16.16 matrix inverse by adjugate over an exact determinant, pipelined.
//
// The core accepts one matrix item in every clock cycle (busy is always low) and
// returns its inverse, one cycle on o_strobe, in acceptance order; the receiver
// must take every item as it appears. The result passes through the long-division
// pipeline, which produces one quotient bit per stage over 34 stages, behind two
// cofactor stages and four determinant stages and followed by one output stage.
// A determinant whose magnitude, in units of 2^-48, is zero or below the singular
// limit gives all zeros with is_singular set. The limit resets to 1 and is written
// through i_cfg_we / i_cfg_data; the user must write it only while no item is in
// flight, which the block does not enforce.
module matrix3x3_inverse_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  m3i_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output m3i_pkg::t_out_item o_item,
    input  logic               i_cfg_we,
    input  m3i_pkg::t_limit    i_cfg_data
);

    m3i_pkg::t_limit   r_limit;
    logic              cof_valid;
    m3i_pkg::t_adj     cof_adj  [m3i_pkg::N_ELEM];
    m3i_pkg::t_word    cof_row0 [3];
    m3i_pkg::t_div_ctl det_ctl;
    m3i_pkg::t_mag     det_rem  [m3i_pkg::N_ELEM];
    m3i_pkg::t_quo     det_nlow [m3i_pkg::N_ELEM];
    m3i_pkg::t_mag     det_div;
    m3i_pkg::t_div_ctl div_ctl;
    m3i_pkg::t_quo     div_q    [m3i_pkg::N_ELEM];

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Singular limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= m3i_pkg::t_limit'(1);
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    m3i_cofactor u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .o_valid (cof_valid),
        .o_adj   (cof_adj),
        .o_row0  (cof_row0)
    );

    m3i_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cof_valid),
        .i_adj   (cof_adj),
        .i_row0  (cof_row0),
        .i_limit (r_limit),
        .o_ctl   (det_ctl),
        .o_rem   (det_rem),
        .o_nlow  (det_nlow),
        .o_div   (det_div)
    );

    m3i_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (det_ctl),
        .i_rem   (det_rem),
        .i_nlow  (det_nlow),
        .i_div   (det_div),
        .o_ctl   (div_ctl),
        .o_q     (div_q)
    );

    m3i_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (div_ctl),
        .i_q      (div_q),
        .o_strobe (o_strobe),
        .o_item   (o_item)
    );

    // Every accepted item comes out after the fixed latency, and nothing else does.
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(m3i_pkg::PIPE_LAT) o_strobe)
        else $error("accepted item did not emerge after the pipeline latency");

    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, m3i_pkg::PIPE_LAT))
        else $error("result strobe without a matching accepted item");

    // A singular result is all zeros and never flagged as saturated; the check covers the diagonal entries.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_item.is_singular) |->
            (!o_item.saturated && o_item.out_r0c0 == '0 && o_item.out_r1c1 == '0
             && o_item.out_r2c2 == '0))
        else $error("singular result carries nonzero data or saturation");

endmodule
